// ===== rtl/uwf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package uwf_pkg;

    // Widths of the timer captures and the millisecond countdown
    localparam int TIMER_BITS    = 16;
    localparam int MS_COUNT_BITS = 12;
    localparam int DRIVE_BITS    = 4;
    localparam int PHASE_BITS    = 2;
    localparam int OP_BITS       = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [TIMER_BITS-1:0]    TIMER_MAX = '1;
    localparam logic [MS_COUNT_BITS-1:0] MS_ONE    = MS_COUNT_BITS'(1);

    // Item opcodes
    localparam logic [OP_BITS-1:0] OP_FRONT = 2'd0;
    localparam logic [OP_BITS-1:0] OP_SIDE  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_TICK  = 2'd2;

    // Track drive patterns: bit3 left fwd, bit2 left back, bit1 right back, bit0 right fwd
    localparam logic [DRIVE_BITS-1:0] DRV_STOP  = 4'h0;
    localparam logic [DRIVE_BITS-1:0] DRV_FWD   = 4'h9;
    localparam logic [DRIVE_BITS-1:0] DRV_LEFT  = 4'h5;
    localparam logic [DRIVE_BITS-1:0] DRV_RIGHT = 4'hA;
    localparam logic [DRIVE_BITS-1:0] DRV_PIVOT = 4'h1;

    // Manoeuvre phases
    localparam logic [PHASE_BITS-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_BITS-1:0] PH_NUDGE = 2'd1;
    localparam logic [PHASE_BITS-1:0] PH_PIVOT = 2'd2;
    localparam logic [PHASE_BITS-1:0] PH_CREEP = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIDE_NEAR   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIDE_FAR    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRONT_CLEAR = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NUDGE_MS    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PIVOT_MS    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CREEP_MS    = 3'd5;

    typedef struct packed {
        logic [OP_BITS-1:0]    op;
        logic [TIMER_BITS-1:0] capture_time;
    } in_item_t;

    typedef struct packed {
        logic [DRIVE_BITS-1:0] motor_drive;
        logic [TIMER_BITS-1:0] front_width;
        logic [TIMER_BITS-1:0] side_width;
        logic [PHASE_BITS-1:0] phase;
    } out_item_t;

    typedef struct packed {
        logic [TIMER_BITS-1:0]    side_near_count;
        logic [TIMER_BITS-1:0]    side_far_count;
        logic [TIMER_BITS-1:0]    front_clear_count;
        logic [MS_COUNT_BITS-1:0] nudge_ms;
        logic [MS_COUNT_BITS-1:0] pivot_ms;
        logic [MS_COUNT_BITS-1:0] creep_ms;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/uwf_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uwf_cfg_regs (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_write,
    input  wire logic [uwf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [uwf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output uwf_pkg::cfg_t                           cfg
);
    import uwf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register write decode; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (cfg_index)
                CFG_SIDE_NEAR:   cfg_next.side_near_count   = cfg_data[TIMER_BITS-1:0];
                CFG_SIDE_FAR:    cfg_next.side_far_count    = cfg_data[TIMER_BITS-1:0];
                CFG_FRONT_CLEAR: cfg_next.front_clear_count = cfg_data[TIMER_BITS-1:0];
                CFG_NUDGE_MS:    cfg_next.nudge_ms          = cfg_data[MS_COUNT_BITS-1:0];
                CFG_PIVOT_MS:    cfg_next.pivot_ms          = cfg_data[MS_COUNT_BITS-1:0];
                CFG_CREEP_MS:    cfg_next.creep_ms          = cfg_data[MS_COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.side_near_count   <= TIMER_BITS'(37);
            cfg_reg.side_far_count    <= TIMER_BITS'(54);
            cfg_reg.front_clear_count <= TIMER_BITS'(104);
            cfg_reg.nudge_ms          <= MS_COUNT_BITS'(30);
            cfg_reg.pivot_ms          <= MS_COUNT_BITS'(2160);
            cfg_reg.creep_ms          <= MS_COUNT_BITS'(600);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/uwf_echo_timer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uwf_echo_timer (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           capture_en,
    input  wire logic [uwf_pkg::TIMER_BITS-1:0] capture_time,
    output logic      [uwf_pkg::TIMER_BITS-1:0] width,
    output logic      [uwf_pkg::TIMER_BITS-1:0] width_next
);
    import uwf_pkg::*;

    logic                  awaiting_fall_reg;
    logic                  awaiting_fall_next;
    logic [TIMER_BITS-1:0] rise_time_reg;
    logic [TIMER_BITS-1:0] rise_time_next;
    logic [TIMER_BITS-1:0] width_reg;

    // First capture of a pair is the rise, second the fall
    always_comb begin
        awaiting_fall_next = awaiting_fall_reg;
        rise_time_next     = rise_time_reg;
        width_next         = width_reg;
        if (capture_en) begin
            if (!awaiting_fall_reg) begin
                rise_time_next     = capture_time;
                awaiting_fall_next = 1'b1;
            end else begin
                awaiting_fall_next = 1'b0;
                if (capture_time > rise_time_reg) begin
                    width_next = capture_time - rise_time_reg;
                end else begin
                    // wrapped or equal: max minus rise plus fall, modulo the timer
                    width_next = (TIMER_MAX - rise_time_reg) + capture_time;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_fall_reg <= 1'b0;
            rise_time_reg     <= '0;
            width_reg         <= '0;
        end else begin
            awaiting_fall_reg <= awaiting_fall_next;
            rise_time_reg     <= rise_time_next;
            width_reg         <= width_next;
        end
    end

    assign width = width_reg;

endmodule

`default_nettype wire

// ===== rtl/uwf_drive_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uwf_drive_fsm (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           tick_en,
    input  wire logic [uwf_pkg::TIMER_BITS-1:0] front_width,
    input  wire logic [uwf_pkg::TIMER_BITS-1:0] side_width,
    input  wire uwf_pkg::cfg_t                  cfg,
    output logic      [uwf_pkg::DRIVE_BITS-1:0] drive_next,
    output logic      [uwf_pkg::PHASE_BITS-1:0] phase_next
);
    import uwf_pkg::*;

    logic [PHASE_BITS-1:0]    phase_reg;
    logic [MS_COUNT_BITS-1:0] countdown_reg;
    logic [MS_COUNT_BITS-1:0] countdown_next;
    logic                     turn_right_reg;
    logic                     turn_right_next;
    logic [DRIVE_BITS-1:0]    drive_reg;

    // Tick handling: decide in idle, count down in a timed phase
    always_comb begin
        phase_next      = phase_reg;
        countdown_next  = countdown_reg;
        turn_right_next = turn_right_reg;
        drive_next      = drive_reg;
        if (tick_en) begin
            if (phase_reg == PH_IDLE) begin
                if (side_width < cfg.side_near_count) begin
                    turn_right_next = 1'b0;
                    phase_next      = PH_NUDGE;
                    drive_next      = DRV_FWD;
                    countdown_next  = cfg.nudge_ms;
                end else if (side_width > cfg.side_far_count) begin
                    turn_right_next = 1'b1;
                    phase_next      = PH_NUDGE;
                    drive_next      = DRV_FWD;
                    countdown_next  = cfg.nudge_ms;
                end else if (front_width > cfg.front_clear_count) begin
                    drive_next = DRV_FWD;
                end else begin
                    phase_next     = PH_PIVOT;
                    drive_next     = DRV_PIVOT;
                    countdown_next = cfg.pivot_ms;
                end
            end else if (countdown_reg > MS_ONE) begin
                countdown_next = countdown_reg - MS_ONE;
            end else begin
                case (phase_reg)
                    PH_NUDGE: begin
                        phase_next     = PH_IDLE;
                        drive_next     = turn_right_reg ? DRV_RIGHT : DRV_LEFT;
                        countdown_next = '0;
                    end
                    PH_PIVOT: begin
                        phase_next     = PH_CREEP;
                        drive_next     = DRV_FWD;
                        countdown_next = cfg.creep_ms;
                    end
                    default: begin
                        phase_next     = PH_IDLE;
                        drive_next     = DRV_STOP;
                        countdown_next = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            countdown_reg  <= '0;
            turn_right_reg <= 1'b0;
            drive_reg      <= DRV_STOP;
        end else begin
            phase_reg      <= phase_next;
            countdown_reg  <= countdown_next;
            turn_right_reg <= turn_right_next;
            drive_reg      <= drive_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ultrasonic_wall_follow_controller.sv =====
// Ultrasonic wall-following track controller.
// Input channel (s_valid/s_ready/s_item): one item per echo capture edge of the
// front or side sensor, or per millisecond tick. Unknown opcodes only report state.
// Result channel (m_valid/m_ready/m_item): exactly one result per input item,
// carrying the track drive, both latest echo widths and the manoeuvre phase.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
// only while no items are in flight.
// Path: an accepted item is held in the input register and is processed as it moves
// into the result register, which then presents its result.
// Throughput: one item per cycle while m_ready is high; the input and result
// registers form two stages; a new item is taken while a result waits on m_item.
// Stalls: when m_ready is low the result register holds, the input register
// fills, and s_ready drops until the result is taken.
// Reset (aresetn low, synchronous): widths, capture pairing and manoeuvre state
// clear to zero, the drive stops, thresholds return to defaults, channels empty.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_wall_follow_controller (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire uwf_pkg::in_item_t                 s_item,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output uwf_pkg::out_item_t                     m_item,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [uwf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [uwf_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import uwf_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      advance;
    logic      front_en;
    logic      side_en;
    logic      tick_en;
    cfg_t      cfg;

    logic [TIMER_BITS-1:0] front_width;
    logic [TIMER_BITS-1:0] front_width_next;
    logic [TIMER_BITS-1:0] side_width;
    logic [TIMER_BITS-1:0] side_width_next;
    logic [DRIVE_BITS-1:0] drive_next;
    logic [PHASE_BITS-1:0] phase_next;

    // Handshake: the item in the input register moves on when the output slot frees
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign front_en = advance && (in_item_reg.op == OP_FRONT);
    assign side_en  = advance && (in_item_reg.op == OP_SIDE);
    assign tick_en  = advance && (in_item_reg.op == OP_TICK);

    uwf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    uwf_echo_timer u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .capture_en   (front_en),
        .capture_time (in_item_reg.capture_time),
        .width        (front_width),
        .width_next   (front_width_next)
    );

    uwf_echo_timer u_side (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .capture_en   (side_en),
        .capture_time (in_item_reg.capture_time),
        .width        (side_width),
        .width_next   (side_width_next)
    );

    uwf_drive_fsm u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick_en     (tick_en),
        .front_width (front_width),
        .side_width  (side_width),
        .cfg         (cfg),
        .drive_next  (drive_next),
        .phase_next  (phase_next)
    );

    // Result is the state as left by this item
    always_comb begin
        out_item_next.motor_drive = drive_next;
        out_item_next.front_width = front_width_next;
        out_item_next.side_width  = side_width_next;
        out_item_next.phase       = phase_next;
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

`ifndef SYNTHESIS
    // No result may be pending straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A buffered item with a free output slot yields a result next cycle
    a_advance_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && (!out_valid_reg || m_ready)) |=> m_valid)
        else $error("item lost between stages");

    // Pivot phase always drives one track only
    a_pivot_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.phase == PH_PIVOT) |-> (m_item.motor_drive == DRV_PIVOT))
        else $error("pivot phase with wrong drive");

    // An empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");
`endif

endmodule

`default_nettype wire

// ===== verif/uwf_drive_checker.sv =====
`timescale 1ns / 1ps

// Watches the item, result and register channels of the wall-follow controller,
// keeps its own copy of the echo and manoeuvre state and checks every result.
module uwf_drive_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    input  wire logic                              s_ready,
    input  uwf_pkg::in_item_t                      s_item,
    input  wire logic                              m_valid,
    input  wire logic                              m_ready,
    input  uwf_pkg::out_item_t                     m_item,
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_ready,
    input  wire logic [uwf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [uwf_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output int                                     mismatches,
    output int                                     results_taken
);
    import uwf_pkg::*;

    // Thresholds and phase lengths as last written
    logic [TIMER_BITS-1:0]    near_thr, far_thr, clear_thr;
    logic [MS_COUNT_BITS-1:0] nudge_len, pivot_len, creep_len;

    // Echo pairing and manoeuvre state
    logic                     front_open, side_open;
    logic [TIMER_BITS-1:0]    front_rise, side_rise, front_w, side_w;
    logic [PHASE_BITS-1:0]    mphase;
    logic [MS_COUNT_BITS-1:0] countdown;
    logic                     turn_right;
    logic [DRIVE_BITS-1:0]    drive;

    out_item_t expected_drive_q[$];

    function automatic void clear_state();
        near_thr   = 16'd37;
        far_thr    = 16'd54;
        clear_thr  = 16'd104;
        nudge_len  = 12'd30;
        pivot_len  = 12'd2160;
        creep_len  = 12'd600;
        front_open = 1'b0;
        side_open  = 1'b0;
        front_rise = '0;
        side_rise  = '0;
        front_w    = '0;
        side_w     = '0;
        mphase     = PH_IDLE;
        countdown  = '0;
        turn_right = 1'b0;
        drive      = DRV_STOP;
    endfunction

    // Fall not above rise is taken as a timer wrap
    function automatic logic [TIMER_BITS-1:0] echo_width(input logic [TIMER_BITS-1:0] rise,
                                                         input logic [TIMER_BITS-1:0] fall);
        if (fall > rise)
            return fall - rise;
        return TIMER_MAX - rise + fall;
    endfunction

    function automatic void start_phase(input logic [PHASE_BITS-1:0]    ph,
                                        input logic [DRIVE_BITS-1:0]    pattern,
                                        input logic [MS_COUNT_BITS-1:0] len);
        mphase    = ph;
        drive     = pattern;
        countdown = len;
    endfunction

    // One millisecond tick: choose a drive when idle, else run the phase timer
    function automatic void ms_tick();
        if (mphase == PH_IDLE) begin
            if (side_w < near_thr) begin
                turn_right = 1'b0;
                start_phase(PH_NUDGE, DRV_FWD, nudge_len);
            end else if (side_w > far_thr) begin
                turn_right = 1'b1;
                start_phase(PH_NUDGE, DRV_FWD, nudge_len);
            end else if (front_w > clear_thr) begin
                drive = DRV_FWD;
            end else begin
                start_phase(PH_PIVOT, DRV_PIVOT, pivot_len);
            end
            return;
        end
        if (countdown > MS_ONE)
            countdown = countdown - MS_ONE;
        else if (mphase == PH_NUDGE)
            start_phase(PH_IDLE, turn_right ? DRV_RIGHT : DRV_LEFT, '0);
        else if (mphase == PH_PIVOT)
            start_phase(PH_CREEP, DRV_FWD, creep_len);
        else
            start_phase(PH_IDLE, DRV_STOP, '0);
    endfunction

    // Apply one accepted item and return the result it should give
    function automatic out_item_t predict_drive(input in_item_t it);
        out_item_t r;
        case (it.op)
            OP_FRONT: begin
                if (!front_open)
                    front_rise = it.capture_time;
                else
                    front_w = echo_width(front_rise, it.capture_time);
                front_open = !front_open;
            end
            OP_SIDE: begin
                if (!side_open)
                    side_rise = it.capture_time;
                else
                    side_w = echo_width(side_rise, it.capture_time);
                side_open = !side_open;
            end
            OP_TICK: ms_tick();
            default: ;
        endcase
        r.motor_drive = drive;
        r.front_width = front_w;
        r.side_width  = side_w;
        r.phase       = mphase;
        return r;
    endfunction

    task automatic report_fault(input string what, input out_item_t want, input out_item_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected drive %h front %h side %h phase %0d,",
                     $time, what, want.motor_drive, want.front_width, want.side_width,
                     want.phase,
                     " got drive %h front %h side %h phase %0d",
                     got.motor_drive, got.front_width, got.side_width, got.phase);
    endtask

    // Results are checked before the item of the same edge is predicted
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            clear_state();
            expected_drive_q.delete();
            mismatches = 0;
            results_taken <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_taken <= results_taken + 1;
                if (expected_drive_q.size() == 0) begin
                    report_fault("result with nothing expected", '0, m_item);
                end else begin
                    want = expected_drive_q.pop_front();
                    if (m_item.motor_drive !== want.motor_drive ||
                        m_item.front_width !== want.front_width ||
                        m_item.side_width !== want.side_width ||
                        m_item.phase !== want.phase)
                        report_fault("result mismatch", want, m_item);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SIDE_NEAR:   near_thr  = cfg_data;
                    CFG_SIDE_FAR:    far_thr   = cfg_data;
                    CFG_FRONT_CLEAR: clear_thr = cfg_data;
                    CFG_NUDGE_MS:    nudge_len = cfg_data[MS_COUNT_BITS-1:0];
                    CFG_PIVOT_MS:    pivot_len = cfg_data[MS_COUNT_BITS-1:0];
                    CFG_CREEP_MS:    creep_len = cfg_data[MS_COUNT_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_drive_q.push_back(predict_drive(s_item));
        end
    end

endmodule

// ===== verif/ultrasonic_wall_follow_controller_tb.sv =====
`timescale 1ns / 1ps

module ultrasonic_wall_follow_controller_tb;
    import uwf_pkg::*;

    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 240;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    in_item_t                 s_item    = '0;
    logic                     m_ready   = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     s_ready, m_valid, cfg_ready;
    out_item_t                m_item;
    int                       mismatches, results_taken;

    int   items_sent     = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   quiet_cycles   = 0;
    bit   hold_request   = 1'b0;
    bit   front_odd      = 1'b0;
    bit   side_odd       = 1'b0;
    cfg_t cur_cfg;

    always #5 aclk = ~aclk;

    ultrasonic_wall_follow_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    uwf_drive_checker drive_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .results_taken (results_taken)
    );

    // Watchdog: too long without any handshake ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(posedge aclk);
                hold_request = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(input logic [OP_BITS-1:0] code,
                             input logic [TIMER_BITS-1:0] stamp);
        in_item_t it;
        it.op           = code;
        it.capture_time = stamp;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (code == OP_FRONT)
            front_odd = !front_odd;
        if (code == OP_SIDE)
            side_odd = !side_odd;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (results_taken != items_sent)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Millisecond registers get junk in the unused upper bits
    task automatic program_regs(input cfg_t c);
        logic [CFG_DATA_BITS-MS_COUNT_BITS-1:0] pad;
        write_reg(CFG_SIDE_NEAR, c.side_near_count);
        write_reg(CFG_SIDE_FAR, c.side_far_count);
        write_reg(CFG_FRONT_CLEAR, c.front_clear_count);
        pad = (CFG_DATA_BITS-MS_COUNT_BITS)'($urandom);
        write_reg(CFG_NUDGE_MS, {pad, c.nudge_ms});
        pad = (CFG_DATA_BITS-MS_COUNT_BITS)'($urandom);
        write_reg(CFG_PIVOT_MS, {pad, c.pivot_ms});
        pad = (CFG_DATA_BITS-MS_COUNT_BITS)'($urandom);
        write_reg(CFG_CREEP_MS, {pad, c.creep_ms});
        cfg_valid <= 1'b0;
        cur_cfg = c;
    endtask

    function automatic cfg_t make_cfg(input logic [TIMER_BITS-1:0] near,
                                      input logic [TIMER_BITS-1:0] far,
                                      input logic [TIMER_BITS-1:0] clear,
                                      input logic [MS_COUNT_BITS-1:0] nudge,
                                      input logic [MS_COUNT_BITS-1:0] pivot,
                                      input logic [MS_COUNT_BITS-1:0] creep);
        cfg_t c;
        c.side_near_count   = near;
        c.side_far_count    = far;
        c.front_clear_count = clear;
        c.nudge_ms          = nudge;
        c.pivot_ms          = pivot;
        c.creep_ms          = creep;
        return c;
    endfunction

    function automatic cfg_t random_cfg();
        logic [TIMER_BITS-1:0] near;
        near = TIMER_BITS'($urandom_range(300));
        return make_cfg(near, near + TIMER_BITS'($urandom_range(300)),
                        TIMER_BITS'($urandom_range(600)), MS_COUNT_BITS'($urandom_range(6)),
                        MS_COUNT_BITS'($urandom_range(6)), MS_COUNT_BITS'($urandom_range(6)));
    endfunction

    // Width close to a threshold, now and then anything at all
    function automatic logic [TIMER_BITS-1:0] width_near(input logic [TIMER_BITS-1:0] base);
        if ($urandom_range(4) == 0)
            return TIMER_BITS'($urandom);
        return base + TIMER_BITS'($urandom_range(8)) - TIMER_BITS'(4);
    endfunction

    // Rise then fall of one sensor; a dangling rise is closed off first
    task automatic capture_pair(input logic [OP_BITS-1:0] code,
                                input logic [TIMER_BITS-1:0] span);
        logic [TIMER_BITS-1:0] rise;
        rise = TIMER_BITS'($urandom);
        if ((code == OP_FRONT) ? front_odd : side_odd)
            send_item(code, TIMER_BITS'($urandom));
        send_item(code, rise);
        send_item(code, rise + span);
    endtask

    // Mostly echo pairs followed by ticks, some tick runs, some noise
    task automatic random_burst();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            if ($urandom_range(1))
                capture_pair(OP_SIDE, width_near($urandom_range(1) ?
                             cur_cfg.side_near_count : cur_cfg.side_far_count));
            else
                capture_pair(OP_FRONT, width_near(cur_cfg.front_clear_count));
            repeat ($urandom_range(1, 6))
                send_item(OP_TICK, TIMER_BITS'($urandom));
        end else if (pick < 85) begin
            repeat ($urandom_range(1, 12))
                send_item(OP_TICK, TIMER_BITS'($urandom));
        end else begin
            repeat ($urandom_range(1, 3))
                send_item(OP_BITS'($urandom_range(3)), TIMER_BITS'($urandom));
        end
    endtask

    // mode 0: no idling, 1: sender idles, 2: receiver stalls, 3: both, lightly
    task automatic run_phase(input int mode, input cfg_t c, input bit long_hold);
        int stop_at;
        wait_drained();
        program_regs(c);
        send_idle_pct  = (mode == 1) ? 88 : (mode == 3) ? 14 : 0;
        recv_stall_pct = (mode == 2) ? 88 : (mode == 3) ? 14 : 0;
        hold_request   = long_hold;
        stop_at        = items_sent + PHASE_ITEMS;
        while (items_sent < stop_at)
            random_burst();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset thresholds: ignored opcode, wrapped and equal edges, clear path
        send_item(OP_UNUSED, '1);
        send_item(OP_FRONT, 16'hFFFF);
        send_item(OP_FRONT, 16'h0000);
        send_item(OP_FRONT, 16'h1000);
        send_item(OP_FRONT, 16'h1000);
        send_item(OP_SIDE, 16'd100);
        send_item(OP_SIDE, 16'd145);
        send_item(OP_TICK, '0);

        // Short phases: left and right correction, pivot then zero-length creep
        wait_drained();
        program_regs(make_cfg(16'd20, 16'd60, 16'd100, 12'd2, 12'd3, 12'd0));
        capture_pair(OP_SIDE, 16'd10);
        repeat (3) send_item(OP_TICK, '0);
        capture_pair(OP_SIDE, 16'd200);
        repeat (3) send_item(OP_TICK, '0);
        capture_pair(OP_SIDE, 16'd40);
        capture_pair(OP_FRONT, 16'd100);
        repeat (5) send_item(OP_TICK, '1);

        run_phase(0, make_cfg(16'd20, 16'd60, 16'd100, 12'd2, 12'd3, 12'd2), 1'b0);
        run_phase(1, make_cfg('0, '0, '0, '0, '0, '0), 1'b0);
        run_phase(2, make_cfg('1, '1, '1, 12'd1, 12'd1, 12'd1), 1'b1);
        run_phase(3, random_cfg(), 1'b0);
        run_phase(0, random_cfg(), 1'b0);
        run_phase(1, random_cfg(), 1'b0);
        run_phase(2, random_cfg(), 1'b0);
        // longest phase timers last, as they never run out
        run_phase(3, make_cfg(16'd37, 16'd54, 16'd104, '1, '1, '1), 1'b0);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && results_taken == items_sent)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
